// ----- rtl/lru_key_value_cache_unit_defines.svh -----
// Assertion macros shared by the LRU key/value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LRUC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LRUC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lruc_pkg.sv -----
// Types and constants shared by the LRU key/value cache modules.
package lruc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  // Request kinds.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Capacity register value after reset.
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // One request item.
  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] req_key;
    logic signed [VAL_W-1:0] req_value;
  } in_t;

  // One result item.
  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } out_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic                    move;
    logic                    hit;
    logic                    evict;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

// ----- rtl/lru_key_value_cache_unit.sv -----
// Top level of the fully associative LRU key/value cache.
// A request is taken on any edge with start high; busy stays low, so one
// request can be issued every clock cycle. The request is registered, then
// in the following cycle the whole row of ENTRIES cells compares its key in
// parallel and shifts by one place toward least recent. The result is
// registered together with the row update and shown on out_data with
// out_strobe high for one cycle.
// That single compare-and-shift pass over the cell row sets the rate. The
// receiver cannot stall, so results must be captured on the strobe cycle.
// Reset clears every valid mark at once; no clearing pass is needed. The
// capacity register is written through the cfg channel, which is always
// ready, and must only be changed while no request is in flight.
`include "lru_key_value_cache_unit_defines.svh"
module lru_key_value_cache_unit import lruc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_strobe,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CMP_W = 9;

  // Request register and capacity register.
  in_t              req_r;
  logic             req_vld_r;
  logic [CFG_W-1:0] cap_r;
  out_t             out_r;
  out_t             out_nxt;
  logic             out_strobe_r;

  // Cell row signals.
  logic signed [KEY_W-1:0] key_arr  [ENTRIES];
  logic signed [VAL_W-1:0] val_arr  [ENTRIES];
  logic [ENTRIES:0]        valid_ext;
  logic [ENTRIES-1:0]      match_vec;
  logic [ENTRIES:0]        seen;
  cell_ctl_t               ctl;

  logic                    hit;
  logic                    full;
  logic [CMP_W-1:0]        eff_idx;
  logic signed [VAL_W-1:0] rd_val;
  logic signed [KEY_W-1:0] last_key;
  logic signed [VAL_W-1:0] head_val;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_data;
    end
  end

  // Slot index of the last entry allowed under the capacity, clamped.
  always_comb begin
    if (cap_r == '0) begin
      eff_idx = '0;
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      eff_idx = CMP_W'(ENTRIES - 1);
    end else begin
      eff_idx = CMP_W'(cap_r) - CMP_W'(1);
    end
  end

  // Valid entries are packed from slot 0, so the store is full exactly
  // when the slot at the capacity boundary is valid.
  always_comb begin
    full = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      full = full | (valid_ext[i] && (eff_idx == CMP_W'(i)));
    end
  end

  // Value of the matching slot and key of the last valid slot.
  always_comb begin
    rd_val   = '0;
    last_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_val   = rd_val | (match_vec[i] ? val_arr[i] : '0);
      last_key = last_key | ((valid_ext[i] && !valid_ext[i+1]) ? key_arr[i] : '0);
    end
  end

  assign hit       = seen[ENTRIES];
  assign seen[0]   = 1'b0;
  assign valid_ext[ENTRIES] = 1'b0;

  // Broadcast control for this cycle's request.
  always_comb begin
    ctl.hit   = hit;
    ctl.evict = (req_r.op == OP_PUT) && !hit && full;
    ctl.move  = req_vld_r && (hit || (req_r.op == OP_PUT));
    ctl.key   = req_r.req_key;
  end

  // A get hit reinserts the stored value; a put writes the new one.
  assign head_val = (req_r.op == OP_GET) ? rd_val : req_r.req_value;

  // Row of cells, slot 0 most recent; each takes its more recent neighbor's item.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic signed [KEY_W-1:0] p_key;
    logic signed [VAL_W-1:0] p_val;
    logic                    p_valid;

    if (g == 0) begin : g_head
      assign p_key   = req_r.req_key;
      assign p_val   = head_val;
      assign p_valid = 1'b1;
    end else begin : g_body
      assign p_key   = key_arr[g-1];
      assign p_val   = val_arr[g-1];
      assign p_valid = valid_ext[g-1];
    end

    lruc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_key   (p_key),
      .prev_val   (p_val),
      .prev_valid (p_valid),
      .seen_in    (seen[g]),
      .key        (key_arr[g]),
      .val        (val_arr[g]),
      .valid      (valid_ext[g]),
      .match      (match_vec[g]),
      .seen_out   (seen[g+1])
    );
  end

  // Result item for the request in the row this cycle.
  always_comb begin
    out_nxt.hit         = hit;
    out_nxt.read_value  = ((req_r.op == OP_GET) && hit) ? rd_val : '1;
    out_nxt.evicted     = ctl.evict;
    out_nxt.evicted_key = ctl.evict ? last_key : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  // Keys are unique among valid slots, so at most one cell matches.
  `LRUC_ASSERT_NOW(a_one_match, 1'b1, $onehot0(match_vec), "more than one slot matched the key")
  // Valid slots stay packed from slot 0 with no gaps.
  `LRUC_ASSERT_NOW(a_packed, 1'b1, ((valid_ext >> 1) & ~valid_ext) == '0, "gap in valid slots")
  // An eviction only happens on a put that missed.
  `LRUC_ASSERT_NOW(a_evict_miss, out_strobe && out_data.evicted, !out_data.hit, "evict on hit")
  // Every request in the row produces exactly one result in the next cycle.
  `LRUC_ASSERT_NEXT(a_result, req_vld_r, out_strobe, "request produced no result")
  // Slot 0 is valid after any request that moved an entry to the front.
  `LRUC_ASSERT_NEXT(a_head_valid, ctl.move, valid_ext[0], "front slot not valid after update")

endmodule

// ----- rtl/lruc_cell.sv -----
// One recency slot of the cache: stored key, value and valid mark.
module lruc_cell import lruc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_ctl_t               ctl,
  input  logic signed [KEY_W-1:0] prev_key,
  input  logic signed [VAL_W-1:0] prev_val,
  input  logic                    prev_valid,
  input  logic                    seen_in,
  output logic signed [KEY_W-1:0] key,
  output logic signed [VAL_W-1:0] val,
  output logic                    valid,
  output logic                    match,
  output logic                    seen_out
);

  logic signed [KEY_W-1:0] key_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    valid_r;
  logic                    shift;

  // Compare against the request and extend the "matched above" chain.
  assign match    = valid_r && (key_r == ctl.key);
  assign seen_out = seen_in | match;

  // On a hit, slots down to the matching one take their neighbor's item.
  // On a put miss, slots down to the last valid one do so (one further
  // when nothing is evicted, since the fill then grows by one).
  always_comb begin
    if (ctl.hit) begin
      shift = ctl.move && !seen_in;
    end else if (ctl.evict) begin
      shift = ctl.move && valid_r;
    end else begin
      shift = ctl.move && prev_valid;
    end
  end

  // Valid mark is control state; key and value are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r <= prev_key;
      val_r <= prev_val;
    end
  end

  assign key   = key_r;
  assign val   = val_r;
  assign valid = valid_r;

endmodule
